// ===== rtl/rpr_pkg.sv =====
// Shared types, codes and GF(2^8) helpers for the RAID6 P+Q column rebuild block.
`default_nettype none

package rpr_pkg;

  // Source of an input byte.
  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_P    = 2'd1,
    KIND_Q    = 2'd2
  } kind_t;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_NONE    = 3'd0,
    ST_VIA_P   = 3'd1,
    ST_VIA_Q   = 3'd2,
    ST_TWO     = 3'd3,
    ST_REFUSED = 3'd4
  } status_t;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_DATA_MEMBERS = 2'd0,
    REG_MISSING_MASK = 2'd1,
    REG_P_PRESENT    = 2'd2,
    REG_Q_PRESENT    = 2'd3
  } cfg_reg_t;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Square-and-multiply steps for a^254 once a^2 is loaded.
  localparam int INV_STEPS = 7;
  localparam int INV_CNT_W = $clog2(INV_STEPS);

  // Powers of the generator 2 for the sixteen possible data members.
  localparam logic [7:0] GF_POW2 [16] = '{
    8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80,
    8'h1D, 8'h3A, 8'h74, 8'hE8, 8'hCD, 8'h87, 8'h13, 8'h26
  };

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic acc;   // fold the accepted item into the column state
    logic load;  // start the inverse: square the operand
    logic step;  // one square-and-multiply step of the inverse
    logic fin1;  // form the syndromes and clear the column state
    logic fin2;  // final multiply and register the result
  } dp_cmd_t;

  // GF(2^8) product with polynomial 0x11D.
  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] x;
    logic [7:0] r;
    x = a;
    r = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) begin
        r = r ^ x;
      end
      x = {x[6:0], 1'b0} ^ (x[7] ? 8'h1D : 8'h00);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/rpr_ctl.sv =====
// Controller state machine for the RAID6 P+Q column rebuild block.
`default_nettype none

module rpr_ctl
  import rpr_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    start,
  input  wire logic    in_last_member,
  input  wire logic    cfg_we,
  output logic         busy,
  output dp_cmd_t      cmd
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_LOAD = 5'b00010,
    S_INV  = 5'b00100,
    S_FIN1 = 5'b01000,
    S_FIN2 = 5'b10000
  } state_t;

  state_t               state_r, state_nxt;
  logic [INV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 take;
  logic                 inv_done;

  assign take     = start && (state_r == S_IDLE);
  assign inv_done = (cnt_r == INV_CNT_W'(INV_STEPS - 1));
  assign busy     = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        cmd.acc = take;
        if (take && in_last_member) begin
          state_nxt = S_FIN1;
        end else if (cfg_we) begin
          state_nxt = S_LOAD;
        end
      end
      S_LOAD: begin
        cmd.load = 1'b1;
        cnt_nxt  = '0;
        if (!cfg_we) begin
          state_nxt = S_INV;
        end
      end
      S_INV: begin
        cmd.step = 1'b1;
        cnt_nxt  = cnt_r + INV_CNT_W'(1);
        if (cfg_we) begin
          state_nxt = S_LOAD;
        end else if (inv_done) begin
          state_nxt = S_IDLE;
        end
      end
      S_FIN1: begin
        cmd.fin1  = 1'b1;
        state_nxt = S_FIN2;
      end
      S_FIN2: begin
        cmd.fin2  = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // A column-ending item always leads straight into the finishing states FIN1 and FIN2.
  a_last_to_fin : assert property (@(posedge clk) disable iff (!rst_n)
    (take && in_last_member) |=> (state_r == S_FIN1))
    else $error("last member did not start the finish sequence");

  a_fin_to_idle : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN2) |=> (state_r == S_IDLE))
    else $error("finish sequence did not return to idle");

  a_inv_count : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_INV) |-> (cnt_r <= INV_CNT_W'(INV_STEPS - 1)))
    else $error("inverse step counter ran past its end");

endmodule

`default_nettype wire

// ===== rtl/rpr_dp.sv =====
// Datapath: configuration, column accumulators, field inverse and result registers.
`default_nettype none

module rpr_dp
  import rpr_pkg::*;
#(
  parameter int MAX_DATA = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire dp_cmd_t               cmd,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic [1:0]            in_kind,
  input  wire logic [3:0]            in_member_index,
  input  wire logic [7:0]            in_byte_value,
  input  wire logic                  in_last_column,
  output logic                       out_valid,
  output logic [2:0]                 out_status,
  output logic [3:0]                 out_first_index,
  output logic [7:0]                 out_first_byte,
  output logic [3:0]                 out_second_index,
  output logic [7:0]                 out_second_byte,
  output logic                       out_row_end
);

  localparam int KCAP = (MAX_DATA < 16) ? MAX_DATA : 16;

  // Configuration registers.
  logic [4:0]  members_r;
  logic [15:0] miss_mask_r;
  logic        p_present_r;
  logic        q_present_r;

  // Column state.
  logic [7:0] xor_acc_r, xor_acc_nxt;
  logic [7:0] wgt_acc_r, wgt_acc_nxt;
  logic [7:0] p_byte_r, p_byte_nxt;
  logic [7:0] q_byte_r, q_byte_nxt;
  logic       row_end_r;

  // Inverse unit and finish stage.
  logic [7:0] inv_r;
  logic [7:0] sq_r;
  logic [7:0] syn_a_r;
  logic [7:0] numer_r;

  // Output registers.
  logic       out_valid_r;
  logic [2:0] status_r;
  logic [3:0] first_idx_r;
  logic [7:0] first_byte_r;
  logic [3:0] second_idx_r;
  logic [7:0] second_byte_r;

  // Derived configuration.
  logic [4:0]  k_eff;
  logic [15:0] eff_mask;
  logic [15:0] mask2;
  logic [15:0] mask3;
  logic [3:0]  idx1;
  logic [3:0]  idx2;
  logic [7:0]  g1;
  logic [7:0]  g2;
  logic [7:0]  inv_op;
  status_t     stat;
  logic        data_ok;
  logic [7:0]  rhs;
  logic [7:0]  prod;

  function automatic logic [3:0] lowest_set(input logic [15:0] m);
    logic [3:0] r;
    r = 4'd0;
    for (int i = 15; i >= 0; i--) begin
      if (m[i]) begin
        r = 4'(i);
      end
    end
    return r;
  endfunction

  assign k_eff = (members_r > 5'(KCAP)) ? 5'(KCAP) : members_r;

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      eff_mask[i] = miss_mask_r[i] && (5'(i) < k_eff);
    end
  end

  // Peel off the lowest missing members one at a time.
  assign mask2  = eff_mask & (eff_mask - 16'd1);
  assign mask3  = mask2 & (mask2 - 16'd1);
  assign idx1   = lowest_set(eff_mask);
  assign idx2   = lowest_set(mask2);
  assign g1     = GF_POW2[idx1];
  assign g2     = GF_POW2[idx2];
  assign inv_op = (mask2 == 16'd0) ? g1 : (g1 ^ g2);

  always_comb begin
    if (eff_mask == 16'd0) begin
      stat = ST_NONE;
    end else if (mask2 == 16'd0) begin
      if (p_present_r) begin
        stat = ST_VIA_P;
      end else if (q_present_r) begin
        stat = ST_VIA_Q;
      end else begin
        stat = ST_REFUSED;
      end
    end else if (mask3 == 16'd0 && p_present_r && q_present_r) begin
      stat = ST_TWO;
    end else begin
      stat = ST_REFUSED;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      members_r   <= 5'd1;
      miss_mask_r <= 16'd0;
      p_present_r <= 1'b1;
      q_present_r <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DATA_MEMBERS: members_r   <= cfg_data[4:0];
        REG_MISSING_MASK: miss_mask_r <= cfg_data[15:0];
        REG_P_PRESENT:    p_present_r <= cfg_data[0];
        REG_Q_PRESENT:    q_present_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Column accumulation; the finish stage clears everything for the next column.
  assign data_ok = ({1'b0, in_member_index} < k_eff) && !miss_mask_r[in_member_index];

  always_comb begin
    xor_acc_nxt = xor_acc_r;
    wgt_acc_nxt = wgt_acc_r;
    p_byte_nxt  = p_byte_r;
    q_byte_nxt  = q_byte_r;
    if (cmd.fin1) begin
      xor_acc_nxt = 8'h00;
      wgt_acc_nxt = 8'h00;
      p_byte_nxt  = 8'h00;
      q_byte_nxt  = 8'h00;
    end else if (cmd.acc) begin
      case (in_kind)
        KIND_DATA: begin
          if (data_ok) begin
            xor_acc_nxt = xor_acc_r ^ in_byte_value;
            wgt_acc_nxt = wgt_acc_r ^ gf_mul(GF_POW2[in_member_index], in_byte_value);
          end
        end
        KIND_P: begin
          if (p_present_r) begin
            p_byte_nxt = in_byte_value;
          end
        end
        KIND_Q: begin
          if (q_present_r) begin
            q_byte_nxt = in_byte_value;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      xor_acc_r <= 8'h00;
      wgt_acc_r <= 8'h00;
      p_byte_r  <= 8'h00;
      q_byte_r  <= 8'h00;
    end else begin
      xor_acc_r <= xor_acc_nxt;
      wgt_acc_r <= wgt_acc_nxt;
      p_byte_r  <= p_byte_nxt;
      q_byte_r  <= q_byte_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.acc) begin
      row_end_r <= in_last_column;
    end
  end

  // Inverse by square-and-multiply: after the load and all steps inv_r holds op^254.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sq_r  <= gf_mul(inv_op, inv_op);
      inv_r <= 8'h01;
    end else if (cmd.step) begin
      sq_r  <= gf_mul(sq_r, sq_r);
      inv_r <= gf_mul(inv_r, sq_r);
    end
  end

  // Finish stage one: syndromes, and for two missing members the numerator.
  assign rhs = q_byte_r ^ wgt_acc_r;

  always_ff @(posedge clk) begin
    if (cmd.fin1) begin
      syn_a_r <= p_byte_r ^ xor_acc_r;
      if (stat == ST_TWO) begin
        numer_r <= rhs ^ gf_mul(g2, p_byte_r ^ xor_acc_r);
      end else begin
        numer_r <= rhs;
      end
    end
  end

  // Finish stage two: scale by the prepared inverse and register the result.
  assign prod = gf_mul(numer_r, inv_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.fin2;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin2) begin
      status_r      <= stat;
      first_idx_r   <= 4'd0;
      first_byte_r  <= 8'h00;
      second_idx_r  <= 4'd0;
      second_byte_r <= 8'h00;
      case (stat)
        ST_VIA_P: begin
          first_idx_r  <= idx1;
          first_byte_r <= syn_a_r;
        end
        ST_VIA_Q: begin
          first_idx_r  <= idx1;
          first_byte_r <= prod;
        end
        ST_TWO: begin
          first_idx_r   <= idx1;
          first_byte_r  <= prod;
          second_idx_r  <= idx2;
          second_byte_r <= syn_a_r ^ prod;
        end
        default: ;
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = status_r;
  assign out_first_index  = first_idx_r;
  assign out_first_byte   = first_byte_r;
  assign out_second_index = second_idx_r;
  assign out_second_byte  = second_byte_r;
  assign out_row_end      = row_end_r;

  a_valid_from_fin : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(cmd.fin2))
    else $error("result strobe without a finish cycle");

  a_single_strobe : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("result strobe lasted more than one cycle");

  a_two_ordered : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && status_r == ST_TWO) |-> (first_idx_r < second_idx_r))
    else $error("two-member rebuild with indices out of order");

endmodule

`default_nettype wire

// ===== rtl/raid6_pq_row_reconstruct.sv =====
// Top level of the RAID6 P+Q column rebuild block: controller plus datapath.
//
//   channel  direction  handshake          payload
//   input    in         start / busy       in_kind, in_member_index, in_byte_value,
//                                          in_last_member, in_last_column
//   result   out        out_valid strobe   out_status, out_first_index, out_first_byte,
//                                          out_second_index, out_second_byte, out_row_end
//   config   in         cfg_we             cfg_index, cfg_data
//
// An item is taken at a rising edge where start is high and busy is low. An item
// that does not end a column leaves busy low unless a configuration write comes with
// it, so member bytes can stream back to back. A column-ending item passes through
// FIN1, the syndrome multiply, and FIN2, the multiply by the prepared inverse; the
// result strobe shows in the cycle right after FIN2, while the block already takes
// the next item. A configuration write that comes neither with a column-ending item
// nor in FIN1 or FIN2 makes the block busy while the square-and-multiply unit prepares
// the field inverse that the rebuild needs. Reset is synchronous and active low; it
// restores the default configuration (one data member, nothing missing, both parities
// present), clears the column state and needs no preparation afterward. The result
// side cannot stall, so results are never held: each strobe lasts exactly one cycle.
`default_nettype none

module raid6_pq_row_reconstruct
  import rpr_pkg::*;
#(
  parameter int MAX_DATA = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // Input items.
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [1:0]            in_kind,
  input  wire logic [3:0]            in_member_index,
  input  wire logic [7:0]            in_byte_value,
  input  wire logic                  in_last_member,
  input  wire logic                  in_last_column,
  // Result items.
  output logic                       out_valid,
  output logic [2:0]                 out_status,
  output logic [3:0]                 out_first_index,
  output logic [7:0]                 out_first_byte,
  output logic [3:0]                 out_second_index,
  output logic [7:0]                 out_second_byte,
  output logic                       out_row_end,
  // Configuration writes.
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  // The controller sequences accumulation, inverse preparation and the
  // finishing states FIN1 and FIN2; the datapath holds every byte of state.
  dp_cmd_t cmd;

  rpr_ctl u_ctl (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .in_last_member (in_last_member),
    .cfg_we         (cfg_we),
    .busy           (busy),
    .cmd            (cmd)
  );

  // The datapath sees the configuration port directly; the number of data
  // members that count is capped by MAX_DATA and by the sixteen mask bits.
  rpr_dp #(
    .MAX_DATA (MAX_DATA)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_kind          (in_kind),
    .in_member_index  (in_member_index),
    .in_byte_value    (in_byte_value),
    .in_last_column   (in_last_column),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_first_index  (out_first_index),
    .out_first_byte   (out_first_byte),
    .out_second_index (out_second_index),
    .out_second_byte  (out_second_byte),
    .out_row_end      (out_row_end)
  );

endmodule

`default_nettype wire

// ===== sim/raid6_pq_row_reconstruct_test.sv =====
// Self-checking testbench for the RAID6 P+Q column rebuild block.
`timescale 1ns / 100ps

module raid6_pq_row_reconstruct_test;
  import rpr_pkg::*;

  // The input kind field is two bits wide, but only three codes carry meaning.
  // The fourth code must be swallowed by the block without any effect.
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  // The block clamps its member count to this many data members.
  localparam int MEMBER_LIMIT = 16;

  // A column-ending item is through with its work once its result has strobed, so
  // this many cycles of quiet after the last result leave the block idle.
  localparam int SETTLE_CYCLES = 8;

  // The watchdog gives up after this many cycles in which no item is
  // accepted, no result strobes and no register is written.
  localparam int STALL_LIMIT = 2000;

  // Number of random input items to aim for.
  localparam int RANDOM_ITEMS = 750;

  // One rebuilt column as the block should report it.
  typedef struct {
    status_t    status;
    logic [3:0] first_index;
    logic [7:0] first_byte;
    logic [3:0] second_index;
    logic [7:0] second_byte;
    logic       row_end;
  } rebuild_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [1:0]  in_kind;
  logic [3:0]  in_member_index;
  logic [7:0]  in_byte_value;
  logic        in_last_member;
  logic        in_last_column;
  logic        out_valid;
  logic [2:0]  out_status;
  logic [3:0]  out_first_index;
  logic [7:0]  out_first_byte;
  logic [3:0]  out_second_index;
  logic [7:0]  out_second_byte;
  logic        out_row_end;
  logic        cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // Shadow copy of the configuration registers, updated at each write edge.
  logic [4:0]  cfg_members;
  logic [15:0] cfg_missing;
  logic        cfg_p_on;
  logic        cfg_q_on;

  // Shadow copy of the per-column accumulators inside the block.
  logic [7:0]  col_xor;
  logic [7:0]  col_weighted;
  logic [7:0]  col_p;
  logic [7:0]  col_q;

  // Rebuilt columns that the block still owes us, oldest first.
  rebuild_t    rebuild_q[$];

  int          fail_count;
  int          random_items;
  int          idle_pct;
  int          quiet_cycles;

  raid6_pq_row_reconstruct dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_kind          (in_kind),
    .in_member_index  (in_member_index),
    .in_byte_value    (in_byte_value),
    .in_last_member   (in_last_member),
    .in_last_column   (in_last_column),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_first_index  (out_first_index),
    .out_first_byte   (out_first_byte),
    .out_second_index (out_second_index),
    .out_second_byte  (out_second_byte),
    .out_row_end      (out_row_end),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // GF(2^8) arithmetic with polynomial 0x11D, written independently of the
  // package so that a shared mistake cannot hide.
  // ---------------------------------------------------------------------------

  // Shift-and-add product: walk the bits of b, doubling a each step and
  // reducing whenever bit 8 would be set.
  function automatic logic [7:0] gf_times(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] acc_a;
    logic [7:0] prod;
    acc_a = {1'b0, a};
    prod  = 8'h00;
    for (int bit_pos = 0; bit_pos < 8; bit_pos++) begin
      if (b[bit_pos]) begin
        prod = prod ^ acc_a[7:0];
      end
      acc_a = acc_a << 1;
      if (acc_a[8]) begin
        acc_a = acc_a ^ 9'h11D;
      end
    end
    return prod;
  endfunction

  // The generator 2 raised to a member index: the Q weight of that member.
  function automatic logic [7:0] gen_power(input int exponent);
    logic [7:0] acc;
    acc = 8'h01;
    for (int n = 0; n < exponent; n++) begin
      acc = gf_times(acc, 8'h02);
    end
    return acc;
  endfunction

  // Every nonzero element satisfies a^255 = 1, so a^254 is its inverse.
  function automatic logic [7:0] gf_reciprocal(input logic [7:0] a);
    logic [7:0] acc;
    acc = 8'h01;
    for (int n = 0; n < 254; n++) begin
      acc = gf_times(acc, a);
    end
    return acc;
  endfunction

  // ---------------------------------------------------------------------------
  // Predictor. Folds one accepted item into the shadow column state and, on
  // the item that ends a column, queues the rebuild the block should report.
  // ---------------------------------------------------------------------------
  task automatic fold_item(input logic [1:0] kind, input logic [3:0] idx,
                           input logic [7:0] val, input logic last,
                           input logic last_col);
    int         members;
    int         lost;
    logic [3:0] lost_a;
    logic [3:0] lost_b;
    logic [7:0] p_syndrome;
    logic [7:0] q_syndrome;
    logic [7:0] numer;
    rebuild_t   r;
    members = (cfg_members > MEMBER_LIMIT) ? MEMBER_LIMIT : int'(cfg_members);
    case (kind)
      KIND_DATA: begin
        // Bytes of absent members and of members beyond the count are ignored.
        if (int'(idx) < members && !cfg_missing[idx]) begin
          col_xor      = col_xor ^ val;
          col_weighted = col_weighted ^ gf_times(gen_power(idx), val);
        end
      end
      KIND_P: begin
        if (cfg_p_on) begin
          col_p = val;
        end
      end
      KIND_Q: begin
        if (cfg_q_on) begin
          col_q = val;
        end
      end
      default: begin
      end
    endcase
    if (!last) begin
      return;
    end

    // Find the two lowest absent members among those in use.
    lost   = 0;
    lost_a = '0;
    lost_b = '0;
    for (int m = 0; m < members; m++) begin
      if (cfg_missing[m]) begin
        if (lost == 0) begin
          lost_a = m[3:0];
        end else if (lost == 1) begin
          lost_b = m[3:0];
        end
        lost++;
      end
    end

    // The syndromes are what the present members leave unexplained.
    p_syndrome     = col_p ^ col_xor;
    q_syndrome     = col_q ^ col_weighted;
    r.status       = ST_NONE;
    r.first_index  = '0;
    r.first_byte   = '0;
    r.second_index = '0;
    r.second_byte  = '0;
    r.row_end      = last_col;
    if (lost == 1) begin
      if (cfg_p_on) begin
        r.status      = ST_VIA_P;
        r.first_index = lost_a;
        r.first_byte  = p_syndrome;
      end else if (cfg_q_on) begin
        r.status      = ST_VIA_Q;
        r.first_index = lost_a;
        r.first_byte  = gf_times(gf_reciprocal(gen_power(lost_a)), q_syndrome);
      end else begin
        r.status = ST_REFUSED;
      end
    end else if (lost == 2 && cfg_p_on && cfg_q_on) begin
      // Solve Da ^ Db = P' and ga*Da ^ gb*Db = Q' for the two lost bytes.
      numer          = q_syndrome ^ gf_times(gen_power(lost_b), p_syndrome);
      r.status       = ST_TWO;
      r.first_index  = lost_a;
      r.first_byte   = gf_times(numer,
                                gf_reciprocal(gen_power(lost_a) ^ gen_power(lost_b)));
      r.second_index = lost_b;
      r.second_byte  = p_syndrome ^ r.first_byte;
    end else if (lost >= 2) begin
      r.status = ST_REFUSED;
    end
    rebuild_q = {rebuild_q, r};

    col_xor      = '0;
    col_weighted = '0;
    col_p        = '0;
    col_q        = '0;
  endtask

  // ---------------------------------------------------------------------------
  // Result checking. Outputs are sampled at the rising edge, which sees the
  // values of the cycle that edge ends.
  // ---------------------------------------------------------------------------
  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    rebuild_t want;
    if (rst_n && out_valid) begin
      if (rebuild_q.size() == 0) begin
        $error("result strobe with no rebuild outstanding (status %0d)", out_status);
        fail_count++;
      end else begin
        want = rebuild_q.pop_front();
        check_field("status",       want.status,       out_status);
        check_field("first_index",  want.first_index,  out_first_index);
        check_field("first_byte",   want.first_byte,   out_first_byte);
        check_field("second_index", want.second_index, out_second_index);
        check_field("second_byte",  want.second_byte,  out_second_byte);
        check_field("row_end",      want.row_end,      out_row_end);
      end
    end
  end

  // Watchdog: a healthy run never goes long without some handshake.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("raid6_pq_row_reconstruct_test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers. Inputs change at the falling edge only.
  // ---------------------------------------------------------------------------

  // Present one item and hold it until the block takes it. Start is left
  // high afterward so that back-to-back items need no extra assignment; the
  // sender's random idling is applied after acceptance, one cycle at a time,
  // so that idle_pct is the share of idle cycles.
  task automatic send_item(input logic [1:0] kind, input logic [3:0] idx,
                           input logic [7:0] val, input logic last,
                           input logic last_col);
    @(negedge clk);
    start           = 1'b1;
    in_kind         = kind;
    in_member_index = idx;
    in_byte_value   = val;
    in_last_member  = last;
    in_last_column  = last_col;
    do begin
      @(posedge clk);
    end while (busy);
    fold_item(kind, idx, val, last, last_col);
    if ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      start = 1'b0;
      while ($urandom_range(99) < idle_pct) begin
        @(negedge clk);
      end
    end
  endtask

  // Stop sending and wait until every owed result has come back and the
  // block has had time to finish any column-ending work.
  task automatic drain;
    @(negedge clk);
    start = 1'b0;
    while (rebuild_q.size() != 0) begin
      @(negedge clk);
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Each write keeps the block busy while it prepares field inverses, so
  // every write waits for the block to be idle first.
  task automatic write_reg(input cfg_reg_t idx, input logic [15:0] val);
    @(negedge clk);
    while (busy) begin
      @(negedge clk);
    end
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(posedge clk);
    case (idx)
      REG_DATA_MEMBERS: cfg_members = val[4:0];
      REG_MISSING_MASK: cfg_missing = val;
      REG_P_PRESENT:    cfg_p_on    = val[0];
      REG_Q_PRESENT:    cfg_q_on    = val[0];
      default: begin
      end
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic set_config(input logic [15:0] members, input logic [15:0] missing,
                            input logic p_on, input logic q_on);
    drain();
    write_reg(REG_DATA_MEMBERS, members);
    write_reg(REG_MISSING_MASK, missing);
    write_reg(REG_P_PRESENT, {15'd0, p_on});
    write_reg(REG_Q_PRESENT, {15'd0, q_on});
  endtask

  // Send one well-formed column for the current configuration: every data
  // member plus consistent P and Q bytes, in a shuffled order. Absent members
  // sometimes still deliver a byte, which the block must ignore. A small share
  // of columns are broken on purpose: a corrupted byte or an early end.
  task automatic send_column(input logic row_last);
    logic [1:0] kinds [20];
    logic [3:0] idxs [20];
    logic [7:0] vals [20];
    logic       lasts [20];
    logic [1:0] tmp_kind;
    logic [3:0] tmp_idx;
    logic [7:0] tmp_val;
    logic [7:0] member_byte;
    logic [7:0] p_sum;
    logic [7:0] q_sum;
    int         members;
    int         count;
    int         swap_at;
    members = (cfg_members > MEMBER_LIMIT) ? MEMBER_LIMIT : int'(cfg_members);
    count   = 0;
    p_sum   = '0;
    q_sum   = '0;
    for (int m = 0; m < members; m++) begin
      member_byte = 8'($urandom_range(255));
      p_sum       = p_sum ^ member_byte;
      q_sum       = q_sum ^ gf_times(gen_power(m), member_byte);
      if (!cfg_missing[m] || $urandom_range(1) == 0) begin
        kinds[count] = KIND_DATA;
        idxs[count]  = m[3:0];
        vals[count]  = member_byte;
        count++;
      end
    end
    if (cfg_p_on || $urandom_range(3) == 0) begin
      kinds[count] = KIND_P;
      idxs[count]  = 4'($urandom_range(15));
      vals[count]  = p_sum;
      count++;
    end
    if (cfg_q_on || $urandom_range(3) == 0) begin
      kinds[count] = KIND_Q;
      idxs[count]  = 4'($urandom_range(15));
      vals[count]  = q_sum;
      count++;
    end
    if (count == 0) begin
      kinds[0] = KIND_DATA;
      idxs[0]  = '0;
      vals[0]  = 8'($urandom_range(255));
      count    = 1;
    end
    for (int n = count - 1; n > 0; n--) begin
      swap_at        = $urandom_range(n);
      tmp_kind       = kinds[n];
      tmp_idx        = idxs[n];
      tmp_val        = vals[n];
      kinds[n]       = kinds[swap_at];
      idxs[n]        = idxs[swap_at];
      vals[n]        = vals[swap_at];
      kinds[swap_at] = tmp_kind;
      idxs[swap_at]  = tmp_idx;
      vals[swap_at]  = tmp_val;
    end
    for (int n = 0; n < count; n++) begin
      lasts[n] = (n == count - 1);
    end
    if ($urandom_range(9) == 0) begin
      swap_at       = $urandom_range(count - 1);
      vals[swap_at] = vals[swap_at] ^ 8'($urandom_range(1, 255));
    end
    if (count > 1 && $urandom_range(11) == 0) begin
      lasts[$urandom_range(count - 2)] = 1'b1;
    end
    for (int n = 0; n < count; n++) begin
      send_item(kinds[n], idxs[n], vals[n], lasts[n], lasts[n] && row_last);
    end
    random_items += count;
  endtask

  // A fully random item, the unused kind code included.
  task automatic send_noise;
    send_item(2'($urandom_range(3)), 4'($urandom_range(15)), 8'($urandom_range(255)),
              $urandom_range(3) == 0, 1'($urandom_range(1)));
  endtask

  // ---------------------------------------------------------------------------
  // Directed tests.
  // ---------------------------------------------------------------------------

  // Out of reset: one data member, nothing missing, both parities present.
  task automatic test_reset_defaults;
    idle_pct = 0;
    send_item(KIND_DATA, 4'd0, 8'hFF, 1'b1, 1'b1);
  endtask

  // One member lost, rebuilt through P, then through Q with P absent. Bytes
  // of the lost member, the unused kind and a P byte while P is absent must
  // all be ignored. The top member index is the lost one in the Q case.
  task automatic test_single_loss;
    set_config(16'd16, 16'h0001, 1'b1, 1'b1);
    send_item(KIND_DATA,   4'd15, 8'hFF, 1'b0, 1'b0);
    send_item(KIND_P,      4'd0,  8'hA5, 1'b0, 1'b0);
    send_item(KIND_UNUSED, 4'd3,  8'h3C, 1'b0, 1'b0);
    send_item(KIND_DATA,   4'd0,  8'h77, 1'b0, 1'b0);
    send_item(KIND_Q,      4'd0,  8'h5A, 1'b1, 1'b0);
    set_config(16'd16, 16'h8000, 1'b0, 1'b1);
    send_item(KIND_DATA,   4'd0,  8'h12, 1'b0, 1'b0);
    send_item(KIND_P,      4'd0,  8'h99, 1'b0, 1'b0);
    send_item(KIND_Q,      4'd0,  8'hFF, 1'b1, 1'b1);
  endtask

  // Two members lost at the ends of the index range. A repeated P byte
  // replaces the earlier one.
  task automatic test_double_loss;
    set_config(16'd16, 16'h8001, 1'b1, 1'b1);
    send_item(KIND_DATA, 4'd7, 8'hFF, 1'b0, 1'b0);
    send_item(KIND_P,    4'd0, 8'h01, 1'b0, 1'b0);
    send_item(KIND_P,    4'd0, 8'h80, 1'b0, 1'b0);
    send_item(KIND_Q,    4'd0, 8'hC3, 1'b1, 1'b0);
  endtask

  // Each way the block must refuse: three lost, one lost with no parity,
  // two lost with a parity missing.
  task automatic test_refusals;
    set_config(16'd16, 16'h0007, 1'b1, 1'b1);
    send_item(KIND_DATA, 4'd3, 8'h00, 1'b1, 1'b0);
    set_config(16'd16, 16'h0001, 1'b0, 1'b0);
    send_item(KIND_DATA, 4'd1, 8'h55, 1'b1, 1'b0);
    set_config(16'd16, 16'h0003, 1'b1, 1'b0);
    send_item(KIND_Q,    4'd0, 8'hAA, 1'b1, 1'b1);
  endtask

  // Member counts at the edges: zero members means nothing can be lost,
  // a count above sixteen is clamped, and mask bits or data bytes beyond
  // the count are ignored.
  task automatic test_member_count_edges;
    set_config(16'd0, 16'hFFFF, 1'b1, 1'b1);
    send_item(KIND_DATA, 4'd0,  8'h81, 1'b1, 1'b0);
    set_config(16'd31, 16'h0800, 1'b1, 1'b1);
    send_item(KIND_DATA, 4'd15, 8'h5A, 1'b0, 1'b0);
    send_item(KIND_P,    4'd0,  8'h0F, 1'b1, 1'b1);
    set_config(16'd4, 16'h0010, 1'b1, 1'b1);
    send_item(KIND_DATA, 4'd9,  8'hE7, 1'b0, 1'b0);
    send_item(KIND_DATA, 4'd3,  8'h3E, 1'b1, 1'b1);
  endtask

  // ---------------------------------------------------------------------------
  // Random columns under random configurations. Each phase picks a setting
  // and an idling level, then streams a handful of columns with some noise.
  // ---------------------------------------------------------------------------
  task automatic test_random_columns;
    int          phase;
    int          members;
    int          pick;
    logic [15:0] missing;
    phase = 0;
    while (random_items < RANDOM_ITEMS) begin
      members = ($urandom_range(9) == 0) ? $urandom_range(31) : $urandom_range(1, 16);
      pick    = $urandom_range(9);
      missing = '0;
      if (pick == 9) begin
        missing = 16'($urandom_range(16'hFFFF));
      end else if (members > 0 && pick >= 3) begin
        // One, two or three lost members inside the member count.
        repeat ((pick < 6) ? 1 : (pick < 8) ? 2 : 3) begin
          missing[$urandom_range((members > MEMBER_LIMIT ? MEMBER_LIMIT : members) - 1)] = 1'b1;
        end
      end
      set_config(16'(members), missing, $urandom_range(4) != 0, $urandom_range(4) != 0);
      case (phase % 3)
        0:       idle_pct = 0;
        1:       idle_pct = 60;
        default: idle_pct = 18;
      endcase
      repeat (8) begin
        if ($urandom_range(7) == 0) begin
          send_noise();
        end
        send_column($urandom_range(3) == 0);
        // Now and then hold off until everything owed has come back.
        if ($urandom_range(7) == 0) begin
          drain();
        end
      end
      phase++;
    end
  endtask

  initial begin
    clk             = 1'b0;
    rst_n           = 1'b0;
    start           = 1'b0;
    in_kind         = KIND_DATA;
    in_member_index = '0;
    in_byte_value   = '0;
    in_last_member  = 1'b0;
    in_last_column  = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = REG_DATA_MEMBERS;
    cfg_data        = '0;
    cfg_members     = 5'd1;
    cfg_missing     = '0;
    cfg_p_on        = 1'b1;
    cfg_q_on        = 1'b1;
    col_xor         = '0;
    col_weighted    = '0;
    col_p           = '0;
    col_q           = '0;
    fail_count      = 0;
    random_items    = 0;
    idle_pct        = 0;

    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    test_reset_defaults();
    test_single_loss();
    test_double_loss();
    test_refusals();
    test_member_count_edges();
    test_random_columns();

    drain();
    if (rebuild_q.size() != 0) begin
      $error("%0d rebuilt columns never reported", rebuild_q.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("raid6_pq_row_reconstruct_test passed");
    end else begin
      $display("raid6_pq_row_reconstruct_test failed");
    end
    $finish;
  end

endmodule
